### hdl/tlfs_pkg.sv
// Shared types and constants for the three-level feedback scheduler.
// No dependencies; compiled first.
package tlfs_pkg;

    localparam int DEF_TASK_SLOTS = 8;
    localparam int NUM_LEVELS     = 3;
    localparam int LVL_W          = 2;
    localparam int QUANT_W        = 4;
    localparam int TIME_W         = 8;
    localparam int SLOT_IN_W      = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;

    typedef enum logic [1:0] {
        ST_ADMITTED = 2'd0,
        ST_RAN      = 2'd1,
        ST_IDLE     = 2'd2,
        ST_BUSY     = 2'd3
    } t_status;

    typedef enum logic {
        ACT_ADMIT    = 1'b0,
        ACT_DISPATCH = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANT0 = 2'd0,
        CFG_QUANT1 = 2'd1,
        CFG_QUANT2 = 2'd2
    } t_cfg_idx;

    localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
    localparam logic [LVL_W-1:0] LVL_BOT = 2'd2;

    localparam logic [QUANT_W-1:0] QUANT0_RST = 4'd1;
    localparam logic [QUANT_W-1:0] QUANT1_RST = 4'd4;
    localparam logic [QUANT_W-1:0] QUANT2_RST = 4'd7;

    typedef struct packed {
        logic             pop_en;
        logic [LVL_W-1:0] pop_lvl;
        logic             push_en;
        logic [LVL_W-1:0] push_lvl;
    } t_fifo_ctl;

    typedef struct packed {
        t_action              action;
        logic [SLOT_IN_W-1:0] task_slot;
        logic [TIME_W-1:0]    burst_time;
    } t_item;

    typedef struct packed {
        t_status              status;
        logic [SLOT_IN_W-1:0] ran_slot;
        logic [LVL_W-1:0]     run_level;
        logic [QUANT_W-1:0]   time_used;
        logic [TIME_W-1:0]    time_left;
        logic [TIME_W-1:0]    cpu_total;
        logic                 finished;
    } t_result;

endpackage

### hdl/tlfs_in_if.sv
// Request channel: admit or dispatch items, valid/ready.
// Depends on tlfs_pkg for field widths.
interface tlfs_in_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [tlfs_pkg::SLOT_IN_W-1:0] task_slot;
    logic [tlfs_pkg::TIME_W-1:0]    burst_time;

    modport source (output valid, action, task_slot, burst_time, input ready);
    modport sink   (input valid, action, task_slot, burst_time, output ready);
endinterface

### hdl/tlfs_out_if.sv
// Result channel: one result per request, valid/ready.
// Depends on tlfs_pkg for field widths.
interface tlfs_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [tlfs_pkg::SLOT_IN_W-1:0] ran_slot;
    logic [tlfs_pkg::LVL_W-1:0]     run_level;
    logic [tlfs_pkg::QUANT_W-1:0]   time_used;
    logic [tlfs_pkg::TIME_W-1:0]    time_left;
    logic [tlfs_pkg::TIME_W-1:0]    cpu_total;
    logic                           finished;

    modport source (output valid, status, ran_slot, run_level, time_used, time_left,
                    cpu_total, finished, input ready);
    modport sink   (input valid, status, ran_slot, run_level, time_used, time_left,
                    cpu_total, finished, output ready);
endinterface

### hdl/tlfs_level_fifos.sv
// Three slot-number queues, one per feedback level, head always at entry 0.
// Depends on tlfs_pkg.
module tlfs_level_fifos #(
    parameter  int TASK_SLOTS = tlfs_pkg::DEF_TASK_SLOTS,
    localparam int SLOT_W     = $clog2(TASK_SLOTS)
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  tlfs_pkg::t_fifo_ctl                          i_ctl,
    input  logic [SLOT_W-1:0]                            i_push_slot,
    output logic [tlfs_pkg::NUM_LEVELS-1:0]              o_nonempty,
    output logic [tlfs_pkg::NUM_LEVELS-1:0][SLOT_W-1:0]  o_head
);
    import tlfs_pkg::*;

    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    logic [SLOT_W-1:0] r_q [NUM_LEVELS][TASK_SLOTS];
    logic [SLOT_W-1:0] n_q [NUM_LEVELS][TASK_SLOTS];
    logic [CNT_W-1:0]  r_cnt [NUM_LEVELS];
    logic [CNT_W-1:0]  n_cnt [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] pop_hit;
    logic [NUM_LEVELS-1:0] push_hit;

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            pop_hit[l]  = i_ctl.pop_en && (i_ctl.pop_lvl == LVL_W'(l));
            push_hit[l] = i_ctl.push_en && (i_ctl.push_lvl == LVL_W'(l));
        end
    end

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (pop_hit[l]) begin
                for (int i = 0; i < TASK_SLOTS - 1; i++) begin
                    n_q[l][i] = r_q[l][i+1];
                end
                n_cnt[l] = r_cnt[l] - CNT_W'(1);
            end
            if (push_hit[l]) begin
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (n_cnt[l] == CNT_W'(i)) begin
                        n_q[l][i] = i_push_slot;
                    end
                end
                n_cnt[l] = n_cnt[l] + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_cnt[l] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            o_head[l]     = r_q[l][0];
            o_nonempty[l] = (r_cnt[l] != '0);
        end
    end

endmodule

### hdl/three_level_feedback_scheduler.sv
// Top level of the three-level feedback queue scheduler.
// Depends on tlfs_pkg, tlfs_in_if, tlfs_out_if and tlfs_level_fifos.
//
// Each request (admit a task into a slot, or dispatch one quantum) yields
// exactly one result. A request passes an input register and is resolved
// against the slot tables and the three level queues, whose update lands in
// the same edge as the result register; the next request therefore sees the
// new state, and one request is taken every cycle while the result is not
// held back. Both sides stall independently: a waiting result does not stop
// the input register from filling. Quantum registers may be written only
// while no request is in flight.
module three_level_feedback_scheduler #(
    parameter int TASK_SLOTS = tlfs_pkg::DEF_TASK_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tlfs_in_if.sink                           i_req,
    tlfs_out_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [tlfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tlfs_pkg::*;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int IW     = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;

    logic [QUANT_W-1:0] r_quant0, r_quant1, r_quant2;
    logic               r_in_vld;
    t_item              r_in;
    logic               r_out_vld;
    t_result            r_out;
    logic [TASK_SLOTS-1:0] r_busy;
    logic [TIME_W-1:0]  r_rem  [TASK_SLOTS];
    logic [TIME_W-1:0]  r_used [TASK_SLOTS];

    logic               advance;
    logic [IW-1:0]      slot_ext;
    logic [SLOT_W-1:0]  adm_idx;
    logic               adm_bad;
    logic               adm_ok;
    logic [NUM_LEVELS-1:0]             ne;
    logic [NUM_LEVELS-1:0][SLOT_W-1:0] heads;
    logic               any_ready;
    logic [LVL_W-1:0]   lvl;
    logic [LVL_W-1:0]   next_lvl;
    logic [SLOT_W-1:0]  head;
    logic [IW-1:0]      head_ext;
    logic [QUANT_W-1:0] quant;
    logic [TIME_W-1:0]  rem;
    logic [QUANT_W-1:0] run;
    logic [TIME_W-1:0]  new_rem;
    logic [TIME_W-1:0]  new_used;
    logic               fin;
    logic               disp_ok;
    t_result            n_res;
    t_fifo_ctl          fifo_ctl;
    logic [SLOT_W-1:0]  push_slot;

    assign advance     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant0 <= QUANT0_RST;
            r_quant1 <= QUANT1_RST;
            r_quant2 <= QUANT2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUANT0: r_quant0 <= i_cfg_data;
                CFG_QUANT1: r_quant1 <= i_cfg_data;
                CFG_QUANT2: r_quant2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.action     <= t_action'(i_req.action);
            r_in.task_slot  <= i_req.task_slot;
            r_in.burst_time <= i_req.burst_time;
        end
    end

    assign slot_ext  = IW'(r_in.task_slot);
    assign adm_idx   = slot_ext[SLOT_W-1:0];
    assign adm_bad   = (32'(r_in.task_slot) >= 32'(TASK_SLOTS)) || r_busy[adm_idx];
    assign any_ready = |ne;

    always_comb begin
        if (ne[0]) begin
            lvl = LVL_TOP;
        end else if (ne[1]) begin
            lvl = LVL_MID;
        end else begin
            lvl = LVL_BOT;
        end
    end

    always_comb begin
        case (lvl)
            LVL_TOP: begin
                quant    = r_quant0;
                next_lvl = LVL_MID;
            end
            LVL_MID: begin
                quant    = r_quant1;
                next_lvl = LVL_BOT;
            end
            default: begin
                quant    = r_quant2;
                next_lvl = LVL_BOT;
            end
        endcase
    end

    assign head     = heads[lvl];
    assign head_ext = IW'(head);
    assign rem      = r_rem[head];
    assign run      = (rem < TIME_W'(quant)) ? rem[QUANT_W-1:0] : quant;
    assign new_rem  = rem - TIME_W'(run);
    assign new_used = r_used[head] + TIME_W'(run);
    assign fin      = (new_rem == '0);
    assign adm_ok   = advance && (r_in.action == ACT_ADMIT) && !adm_bad;
    assign disp_ok  = advance && (r_in.action == ACT_DISPATCH) && any_ready;

    always_comb begin
        n_res = '0;
        case (r_in.action)
            ACT_ADMIT: begin
                n_res.ran_slot = r_in.task_slot;
                if (adm_bad) begin
                    n_res.status = ST_BUSY;
                end else begin
                    n_res.status    = ST_ADMITTED;
                    n_res.time_left = r_in.burst_time;
                end
            end
            ACT_DISPATCH: begin
                if (!any_ready) begin
                    n_res.status = ST_IDLE;
                end else begin
                    n_res.status    = ST_RAN;
                    n_res.ran_slot  = head_ext[SLOT_IN_W-1:0];
                    n_res.run_level = lvl;
                    n_res.time_used = run;
                    n_res.time_left = new_rem;
                    n_res.cpu_total = new_used;
                    n_res.finished  = fin;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        fifo_ctl.pop_en   = disp_ok;
        fifo_ctl.pop_lvl  = lvl;
        fifo_ctl.push_en  = adm_ok || (disp_ok && !fin);
        fifo_ctl.push_lvl = adm_ok ? LVL_TOP : next_lvl;
        push_slot         = adm_ok ? adm_idx : head;
    end

    tlfs_level_fifos #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_fifos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fifo_ctl),
        .i_push_slot (push_slot),
        .o_nonempty  (ne),
        .o_head      (heads)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (adm_ok) begin
            r_busy[adm_idx] <= 1'b1;
        end else if (disp_ok && fin) begin
            r_busy[head] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adm_ok) begin
            r_rem[adm_idx]  <= r_in.burst_time;
            r_used[adm_idx] <= '0;
        end else if (disp_ok) begin
            r_rem[head]  <= new_rem;
            r_used[head] <= new_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_res;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.ran_slot  = r_out.ran_slot;
    assign o_rsp.run_level = r_out.run_level;
    assign o_rsp.time_used = r_out.time_used;
    assign o_rsp.time_left = r_out.time_left;
    assign o_rsp.cpu_total = r_out.cpu_total;
    assign o_rsp.finished  = r_out.finished;

    a_busy_matches_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_busy) == any_ready)
        else $error("busy slots and queued levels disagree");

    a_finish_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (disp_ok && fin) |=> !r_busy[$past(head)])
        else $error("finished task still holds its slot");

    a_finished_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.finished) |-> (r_out.status == ST_RAN && r_out.time_left == '0))
        else $error("finished result with time left");

    a_run_within_quantum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        disp_ok |-> (run <= quant && TIME_W'(run) <= rem))
        else $error("run exceeds quantum or remaining time");

endmodule
